[src/diag_reply_frame_receiver_macros.svh]
// Assertion helpers for the checker file drfr_checker.sv.
`ifndef DIAG_REPLY_FRAME_RECEIVER_MACROS_SVH
`define DIAG_REPLY_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DRFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drfr check failed");

// Next-cycle implication, disabled while reset is low.
`define DRFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drfr check failed");

`endif

[src/drfr_pkg.sv]
`default_nettype none

package drfr_pkg;

  // Status codes reported with each result item
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HEADER   = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;
  localparam logic [1:0] ST_OVERLEN  = 2'd3;

  // Fixed reply header bytes
  localparam logic [7:0] HDR_BYTE0 = 8'h80;
  localparam logic [7:0] HDR_BYTE1 = 8'hF0;

  // Input mode codes
  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_BYTE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_UNIT_ADDRESS = 1'b0;
  localparam logic CFG_ECHO_COUNT   = 1'b1;

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic       frame_done;
    logic       last_byte;
    logic       data_valid;
    logic [7:0] data_byte;
  } result_t;

endpackage

`default_nettype wire

[src/drfr_core.sv]
`default_nettype none

module drfr_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire logic             mode,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [7:0]       unit_address,
  input  wire logic [8:0]       echo_count,
  output drfr_pkg::result_t     res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ECHO, PH_HEADER, PH_LENGTH, PH_PAYLOAD, PH_CHECK, PH_DONE, PH_ERROR
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [8:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] payload_length_r, payload_length_nxt;
  logic [1:0] error_code_r, error_code_nxt;

  // Work out the next state and the result item for the item on the input
  always_comb begin
    logic [7:0] expect_byte;
    logic [8:0] count_inc;
    expect_byte        = unit_address;
    count_inc          = byte_count_r + 9'd1;
    phase_nxt          = phase_r;
    byte_count_nxt     = byte_count_r;
    running_sum_nxt    = running_sum_r;
    payload_length_nxt = payload_length_r;
    error_code_nxt     = error_code_r;
    res                = '0;

    if (mode == drfr_pkg::MODE_BEGIN) begin
      byte_count_nxt     = '0;
      running_sum_nxt    = '0;
      payload_length_nxt = '0;
      error_code_nxt     = drfr_pkg::ST_OK;
      phase_nxt          = (echo_count == 9'd0) ? PH_HEADER : PH_ECHO;
    end else begin
      case (phase_r)
        PH_ECHO: begin
          byte_count_nxt = count_inc;
          if (count_inc >= echo_count) begin
            byte_count_nxt = '0;
            phase_nxt      = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (byte_count_r == 9'd0) begin
            expect_byte = drfr_pkg::HDR_BYTE0;
          end else if (byte_count_r == 9'd1) begin
            expect_byte = drfr_pkg::HDR_BYTE1;
          end
          running_sum_nxt = running_sum_r + rx_byte;
          if (rx_byte != expect_byte) begin
            error_code_nxt = drfr_pkg::ST_HEADER;
            phase_nxt      = PH_ERROR;
            res.frame_done = 1'b1;
            res.status     = drfr_pkg::ST_HEADER;
          end else if (byte_count_r >= 9'd2) begin
            byte_count_nxt = '0;
            phase_nxt      = PH_LENGTH;
          end else begin
            byte_count_nxt = count_inc;
          end
        end
        PH_LENGTH: begin
          running_sum_nxt    = running_sum_r + rx_byte;
          payload_length_nxt = rx_byte;
          byte_count_nxt     = '0;
          phase_nxt          = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_sum_nxt = running_sum_r + rx_byte;
          res.data_byte   = rx_byte;
          res.data_valid  = 1'b1;
          byte_count_nxt  = count_inc;
          if (count_inc >= {1'b0, payload_length_r}) begin
            res.last_byte = 1'b1;
            phase_nxt     = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res.frame_done = 1'b1;
          if (rx_byte != running_sum_r) begin
            error_code_nxt = drfr_pkg::ST_CHECKSUM;
            phase_nxt      = PH_ERROR;
            res.status     = drfr_pkg::ST_CHECKSUM;
          end else begin
            phase_nxt  = PH_DONE;
            res.status = drfr_pkg::ST_OK;
          end
        end
        PH_DONE: begin
          error_code_nxt = drfr_pkg::ST_OVERLEN;
          phase_nxt      = PH_ERROR;
          res.frame_done = 1'b1;
          res.status     = drfr_pkg::ST_OVERLEN;
        end
        PH_ERROR: begin
          res.status = error_code_r;
        end
        default: begin
          // idle: line bytes are dropped
        end
      endcase
    end
  end

  // Hold receiver state; advance only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      byte_count_r     <= '0;
      running_sum_r    <= '0;
      payload_length_r <= '0;
      error_code_r     <= drfr_pkg::ST_OK;
    end else if (take) begin
      phase_r          <= phase_nxt;
      byte_count_r     <= byte_count_nxt;
      running_sum_r    <= running_sum_nxt;
      payload_length_r <= payload_length_nxt;
      error_code_r     <= error_code_nxt;
    end
  end

endmodule

`default_nettype wire

[src/drfr_obuf.sv]
`default_nettype none

module drfr_obuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire drfr_pkg::result_t push_data,
  output logic                   can_push,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output drfr_pkg::result_t      out_data
);

  logic              main_valid_r;
  logic              skid_valid_r;
  drfr_pkg::result_t main_r;
  drfr_pkg::result_t skid_r;
  logic              pop;

  assign pop       = main_valid_r & out_ready;
  assign can_push  = ~skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Two-entry buffer: result register plus skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

[src/diag_reply_frame_receiver.sv]
// Channel  Dir  tdata          tuser                                   tlast
// in_      in   rx_byte[7:0]   mode                                    -
// out_     out  data_byte[7:0] data_valid, frame_done, status[1:0]     last_byte
// cfg_     in   cfg_we write enable, cfg_addr register index, cfg_wdata[8:0]
//
// One item per cycle while out_tready is high; one result item per input item.
// Receiver state updates in the accept cycle; the result item is registered in
// the output buffer. A two-entry output buffer lets one more item in
// while out_tready is low; in_tready drops once both entries are full.
// Reset (rst_n low, synchronous) sets the idle phase and default registers.
`default_nettype none

module diag_reply_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_byte
  input  wire logic       in_tuser,   // [0] mode
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] data_byte
  output logic [3:0]      out_tuser,  // [0] data_valid, [1] frame_done, [3:2] status
  output logic            out_tlast,  // last_byte
  input  wire logic       cfg_we,
  input  wire logic       cfg_addr,
  input  wire logic [8:0] cfg_wdata
);

  logic              take;
  logic [7:0]        unit_address_r;
  logic [8:0]        echo_count_r;
  drfr_pkg::result_t res;
  drfr_pkg::result_t out_res;

  assign take = in_tvalid & in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_address_r <= 8'd16;
      echo_count_r   <= 9'd6;
    end else if (cfg_we) begin
      case (cfg_addr)
        drfr_pkg::CFG_UNIT_ADDRESS: unit_address_r <= cfg_wdata[7:0];
        drfr_pkg::CFG_ECHO_COUNT:   echo_count_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  drfr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .mode         (in_tuser),
    .rx_byte      (in_tdata),
    .unit_address (unit_address_r),
    .echo_count   (echo_count_r),
    .res          (res)
  );

  drfr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (res),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack the result item onto the stream ports
  assign out_tdata = out_res.data_byte;
  assign out_tuser = {out_res.status, out_res.frame_done, out_res.data_valid};
  assign out_tlast = out_res.last_byte;

endmodule

`default_nettype wire

[src/drfr_checker.sv]
`default_nettype none
`include "diag_reply_frame_receiver_macros.svh"

module drfr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [3:0] out_tuser,
  input wire logic       out_tlast
);

  // Data byte is zero unless it carries payload
  `DRFR_ASSERT_IMP(a_data_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == 8'd0)

  // Last marker only on a payload item
  `DRFR_ASSERT_IMP(a_last_on_data, clk, rst_n, out_tvalid && out_tlast, out_tuser[0])

  // Payload never reported together with frame end or an error status
  `DRFR_ASSERT_IMP(a_data_clean, clk, rst_n, out_tvalid && out_tuser[0],
                   !out_tuser[1] && out_tuser[3:2] == drfr_pkg::ST_OK)

  // A stalled result item holds
  `DRFR_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind diag_reply_frame_receiver drfr_checker u_drfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[tb/sv/drfr_reply_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the register port of the reply frame receiver,
// predicts one result item per accepted input item and compares in order.
module drfr_reply_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [3:0] out_tuser,
  input  logic       out_tlast,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [8:0] cfg_wdata,
  output int         pending_results,
  output int         mismatch_count
);

  typedef enum logic [2:0] {
    RX_IDLE, RX_ECHO, RX_HEADER, RX_LENGTH, RX_PAYLOAD, RX_CHECK, RX_DONE, RX_ERROR
  } rx_phase_t;

  // Shadow copy of the receiver registers and state
  logic [7:0] unit_address_reg;
  logic [8:0] echo_count_reg;
  rx_phase_t  rx_phase;
  logic [8:0] byte_cnt;
  logic [7:0] frame_sum;
  logic [7:0] frame_len;
  logic [1:0] latched_status;

  drfr_pkg::result_t expected_replies[$];
  int                mismatch_total = 0;

  // Latch the first error of the frame and report it
  function automatic drfr_pkg::result_t flag_fault(input logic [1:0] code);
    drfr_pkg::result_t r;
    r              = '0;
    latched_status = code;
    rx_phase       = RX_ERROR;
    r.frame_done   = 1'b1;
    r.status       = code;
    return r;
  endfunction

  // Advance the receiver by one item and return the reply it produces
  function automatic drfr_pkg::result_t reply_for_item(input logic mode,
                                                       input logic [7:0] b);
    drfr_pkg::result_t r;
    logic [7:0]        want;
    r = '0;
    if (mode == drfr_pkg::MODE_BEGIN) begin
      byte_cnt       = '0;
      frame_sum      = '0;
      frame_len      = '0;
      latched_status = drfr_pkg::ST_OK;
      rx_phase       = (echo_count_reg == '0) ? RX_HEADER : RX_ECHO;
      return r;
    end
    case (rx_phase)
      RX_ECHO: begin
        byte_cnt = byte_cnt + 9'd1;
        if (byte_cnt >= echo_count_reg) begin
          byte_cnt = '0;
          rx_phase = RX_HEADER;
        end
      end
      RX_HEADER: begin
        want = (byte_cnt == 9'd0) ? drfr_pkg::HDR_BYTE0 :
               (byte_cnt == 9'd1) ? drfr_pkg::HDR_BYTE1 : unit_address_reg;
        frame_sum = frame_sum + b;
        if (b != want) begin
          r = flag_fault(drfr_pkg::ST_HEADER);
        end else if (byte_cnt >= 9'd2) begin
          byte_cnt = '0;
          rx_phase = RX_LENGTH;
        end else begin
          byte_cnt = byte_cnt + 9'd1;
        end
      end
      RX_LENGTH: begin
        frame_sum = frame_sum + b;
        frame_len = b;
        byte_cnt  = '0;
        rx_phase  = (b == 8'd0) ? RX_CHECK : RX_PAYLOAD;
      end
      RX_PAYLOAD: begin
        frame_sum    = frame_sum + b;
        r.data_byte  = b;
        r.data_valid = 1'b1;
        byte_cnt     = byte_cnt + 9'd1;
        if (byte_cnt >= {1'b0, frame_len}) begin
          r.last_byte = 1'b1;
          rx_phase    = RX_CHECK;
        end
      end
      RX_CHECK: begin
        if (b != frame_sum) begin
          r = flag_fault(drfr_pkg::ST_CHECKSUM);
        end else begin
          rx_phase     = RX_DONE;
          r.frame_done = 1'b1;
          r.status     = drfr_pkg::ST_OK;
        end
      end
      RX_DONE: r = flag_fault(drfr_pkg::ST_OVERLEN);
      RX_ERROR: r.status = latched_status;
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want_val,
                             input logic [7:0] got_val);
    if (want_val !== got_val) begin
      $error("%s mismatch: expected %0d, got %0d", field, want_val, got_val);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    drfr_pkg::result_t want_reply;
    if (!rst_n) begin
      unit_address_reg = 8'd16;
      echo_count_reg   = 9'd6;
      rx_phase         = RX_IDLE;
      byte_cnt         = '0;
      frame_sum        = '0;
      frame_len        = '0;
      latched_status   = drfr_pkg::ST_OK;
      expected_replies.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_addr)
          drfr_pkg::CFG_UNIT_ADDRESS: unit_address_reg = cfg_wdata[7:0];
          drfr_pkg::CFG_ECHO_COUNT:   echo_count_reg   = cfg_wdata;
          default: ;
        endcase
      end
      // Compare an accepted result item with the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("result item with no expectation: tdata %0h tuser %0h tlast %0b",
                 out_tdata, out_tuser, out_tlast);
          mismatch_total++;
        end else begin
          want_reply = expected_replies.pop_front();
          check_field("data_byte", want_reply.data_byte, out_tdata);
          check_field("data_valid", 8'(want_reply.data_valid), 8'(out_tuser[0]));
          check_field("last_byte", 8'(want_reply.last_byte), 8'(out_tlast));
          check_field("frame_done", 8'(want_reply.frame_done), 8'(out_tuser[1]));
          check_field("status", 8'(want_reply.status), 8'(out_tuser[3:2]));
        end
      end
      // Predict the reply of an accepted input item
      if (in_tvalid && in_tready)
        expected_replies.push_back(reply_for_item(in_tuser, in_tdata));
    end
    pending_results <= expected_replies.size();
    mismatch_count  <= mismatch_total;
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 60;
  localparam int PHASE_ITEMS   = 470;
  localparam int DRAIN_CYCLES  = 8;

  typedef enum {
    FR_GOOD, FR_BAD_HEADER, FR_BAD_SUM, FR_TRAILING, FR_CUT_SHORT, FR_MISALIGNED
  } frame_fault_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tuser = drfr_pkg::MODE_BEGIN;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       out_tlast;
  logic       cfg_we = 1'b0;
  logic       cfg_addr = drfr_pkg::CFG_UNIT_ADDRESS;
  logic [8:0] cfg_wdata = '0;

  int pending_results;
  int mismatch_count;

  int          send_idle_pct = 34;
  int          recv_idle_pct = 69;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  logic [7:0]  cur_unit = 8'd16;
  logic [8:0]  cur_echo = 9'd6;

  always #4 clk = ~clk;

  diag_reply_frame_receiver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  drfr_reply_checker reply_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("diag_reply_frame_receiver test failed");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic mode, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result item has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_reg(input logic addr, input logic [8:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send one exchange: begin, echoes, header, length, payload, checksum, with the fault applied
  task automatic send_frame(input int unsigned echo_n, input int unsigned pay_len,
                            input frame_fault_t fault);
    logic [7:0]  hdr [3];
    logic [7:0]  sum;
    logic [7:0]  value;
    int unsigned bad_pos;
    int unsigned cut_at;
    hdr[0]  = drfr_pkg::HDR_BYTE0;
    hdr[1]  = drfr_pkg::HDR_BYTE1;
    hdr[2]  = cur_unit;
    sum     = '0;
    bad_pos = $urandom_range(2);
    cut_at  = (pay_len == 0) ? 0 : $urandom_range(pay_len - 1);
    if (fault == FR_BAD_HEADER)
      hdr[bad_pos] = hdr[bad_pos] ^ 8'($urandom_range(255, 1));
    send_item(drfr_pkg::MODE_BEGIN, 8'($urandom));
    repeat (echo_n) send_item(drfr_pkg::MODE_BYTE, 8'($urandom));
    for (int i = 0; i < 3; i++) begin
      send_item(drfr_pkg::MODE_BYTE, hdr[i]);
      sum = sum + hdr[i];
      if (fault == FR_BAD_HEADER && i == bad_pos) return;
    end
    send_item(drfr_pkg::MODE_BYTE, 8'(pay_len));
    sum = sum + 8'(pay_len);
    for (int i = 0; i < pay_len; i++) begin
      if (fault == FR_CUT_SHORT && i == cut_at) return;
      value = 8'($urandom);
      send_item(drfr_pkg::MODE_BYTE, value);
      sum = sum + value;
    end
    // an empty frame cut short stops before its checksum
    if (fault == FR_CUT_SHORT) return;
    send_item(drfr_pkg::MODE_BYTE,
              (fault == FR_BAD_SUM) ? sum ^ 8'($urandom_range(255, 1)) : sum);
    if (fault == FR_TRAILING) repeat (2) send_item(drfr_pkg::MODE_BYTE, 8'($urandom));
  endtask

  initial begin
    int           phase_start;
    int           frames;
    int           roll;
    int unsigned  echo_n;
    int unsigned  pay_len;
    frame_fault_t fault;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte before any begin is ignored
    send_item(drfr_pkg::MODE_BYTE, 8'hFF);
    // good empty frame at reset settings, then overlength and an ignored byte
    send_frame(cur_echo, 0, FR_TRAILING);
    // shrink the echo count while echoes are being dropped
    send_item(drfr_pkg::MODE_BEGIN, 8'h00);
    repeat (3) send_item(drfr_pkg::MODE_BYTE, 8'($urandom));
    cur_echo = 9'd0;
    write_reg(drfr_pkg::CFG_ECHO_COUNT, cur_echo);
    send_item(drfr_pkg::MODE_BYTE, 8'($urandom));
    send_item(drfr_pkg::MODE_BYTE, drfr_pkg::HDR_BYTE1);
    // no echoes, payload at both byte extremes, wrong checksum
    send_item(drfr_pkg::MODE_BEGIN, 8'hFF);
    send_item(drfr_pkg::MODE_BYTE, drfr_pkg::HDR_BYTE0);
    send_item(drfr_pkg::MODE_BYTE, drfr_pkg::HDR_BYTE1);
    send_item(drfr_pkg::MODE_BYTE, cur_unit);
    send_item(drfr_pkg::MODE_BYTE, 8'd2);
    send_item(drfr_pkg::MODE_BYTE, 8'h00);
    send_item(drfr_pkg::MODE_BYTE, 8'hFF);
    send_item(drfr_pkg::MODE_BYTE,
              8'(drfr_pkg::HDR_BYTE0 + drfr_pkg::HDR_BYTE1 + cur_unit + 8'd2 + 8'hFF)
              ^ 8'h01);

    // Random exchanges under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 69 : 0;
      recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 34 : 0;
      case (ph)
        0: begin cur_unit = 8'd0;   cur_echo = 9'd0;   end
        1: begin cur_unit = 8'd255; cur_echo = 9'd511; end
        default: begin cur_unit = 8'($urandom); cur_echo = 9'd260; end
      endcase
      write_reg(drfr_pkg::CFG_UNIT_ADDRESS, {1'b0, cur_unit});
      write_reg(drfr_pkg::CFG_ECHO_COUNT, cur_echo);
      phase_start = items_sent;
      frames = 0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // long receiver hold-off while items keep coming
        if (frames == 3) hold_requests++;
        if (frames == 6) wait_drained();
        // move to a fresh setting, mostly short echo runs
        if (frames == 1 || (frames > 0 && frames % 8 == 0)) begin
          roll = $urandom_range(99);
          cur_unit = 8'($urandom);
          cur_echo = (roll < 75) ? 9'($urandom_range(10)) :
                     (roll < 97) ? 9'($urandom_range(40, 11)) : 9'd260;
          write_reg(drfr_pkg::CFG_UNIT_ADDRESS, {1'b0, cur_unit});
          write_reg(drfr_pkg::CFG_ECHO_COUNT, cur_echo);
        end
        // line noise ahead of the exchange
        if ($urandom_range(99) < 5)
          repeat ($urandom_range(3, 1)) send_item(drfr_pkg::MODE_BYTE, 8'($urandom));
        roll  = $urandom_range(99);
        fault = (roll < 60) ? FR_GOOD :
                (roll < 70) ? FR_BAD_HEADER :
                (roll < 80) ? FR_BAD_SUM :
                (roll < 88) ? FR_TRAILING :
                (roll < 95) ? FR_CUT_SHORT : FR_MISALIGNED;
        roll    = $urandom_range(99);
        pay_len = (roll < 85) ? $urandom_range(8) :
                  (roll < 98) ? $urandom_range(40, 9) : 255;
        echo_n  = cur_echo;
        if (fault == FR_MISALIGNED)
          echo_n = (cur_echo == 0 || $urandom_range(1)) ? cur_echo + 1 : cur_echo - 1;
        send_frame(echo_n, pay_len, fault);
        frames++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("diag_reply_frame_receiver test passed");
    end else begin
      $display("diag_reply_frame_receiver test failed");
    end
    $finish;
  end

endmodule
